/* rtl/core/bhpt_pkg.sv */
// Shared types and constants of the bit history probability table.
`timescale 1ns / 1ps

package bhpt_pkg;

  // Command codes of an input item
  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Width of the successor and probability result fields
  localparam int SUCC_W = 8;
  localparam int PROB_W = 16;

  typedef struct packed {
    logic       cmd;
    logic       bit_value;
    logic [7:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [SUCC_W-1:0] next_on_zero;
    logic [SUCC_W-1:0] next_on_one;
    logic [PROB_W-1:0] one_probability;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr;       // write one zero entry of the clearing pass
    logic accept;    // capture an item and read its table entry
    logic upd;       // update counters and history for an observed bit
    logic div_load;  // start the probability division
    logic div_step;  // run one quotient bit
    logic emit;      // load the result register
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;    // clearing pass at the last entry
    logic total_zero;  // entry read has a zero total
    logic div_done;    // last quotient bit in this step
  } stat_t;

endpackage

/* rtl/core/bit_history_probability_table_top.sv */
// Top level of the bit history probability table.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+-------------------------------------
//  input    | start, busy, in_item       | item taken at an edge with start & !busy
//  result   | out_valid, out_item        | one-cycle strobe, cannot be held off
//
// An observe item does one table read at its accept, then one counter write.
// A read item reads the table, loads the restoring divider, runs its steps (none when
// the entry total is zero) and loads the result; the divider gives one quotient bit a cycle.
// After reset a clearing pass writes all 2^HISTORY_BITS table entries, one a
// cycle, while busy is high. The result strobe follows the item's last busy
// cycle; the next item may be taken in that same cycle.
`timescale 1ns / 1ps

module bit_history_probability_table_top #(
  parameter int HISTORY_BITS   = 8,
  parameter int PROB_FRAC_BITS = 15,
  parameter int COUNT_BITS     = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bhpt_pkg::in_t  in_item,
  output logic           out_valid,
  output bhpt_pkg::out_t out_item
);
  import bhpt_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // Sequence the work of each item
  bhpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (in_item.cmd),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold the table and compute results
  bhpt_dp #(
    .HISTORY_BITS   (HISTORY_BITS),
    .PROB_FRAC_BITS (PROB_FRAC_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .stat     (stat),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

/* rtl/core/bhpt_dp.sv */
// Datapath: count table, history, warm-up counter, divider and result register.
`timescale 1ns / 1ps

module bhpt_dp #(
  parameter int HISTORY_BITS   = 8,
  parameter int PROB_FRAC_BITS = 15,
  parameter int COUNT_BITS     = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bhpt_pkg::ctl_t  ctl,
  output bhpt_pkg::stat_t stat,
  input  bhpt_pkg::in_t   in_item,
  output bhpt_pkg::out_t  out_item
);
  import bhpt_pkg::*;

  localparam int DEPTH = 1 << HISTORY_BITS;
  localparam int WW    = 2 * COUNT_BITS;
  localparam int QW    = PROB_FRAC_BITS + 1;
  localparam int CW    = $clog2(PROB_FRAC_BITS + 1);
  localparam int SW    = (QW > PROB_W) ? QW : PROB_W;

  logic [WW-1:0]           mem [DEPTH];
  logic [WW-1:0]           rd_r;
  logic [HISTORY_BITS-1:0] history_r, history_nxt;
  logic [HISTORY_BITS-1:0] addr_r;
  logic [HISTORY_BITS-1:0] clr_addr_r;
  logic [3:0]              warmup_r, warmup_nxt;
  logic                    bit_r;
  logic [COUNT_BITS-1:0]   rem_r;
  logic [QW-1:0]           quo_r;
  logic [CW-1:0]           step_r;
  out_t                    out_r;

  logic [HISTORY_BITS-1:0] idx_h, rd_addr, wr_addr;
  logic [COUNT_BITS-1:0]   zeros, total, ones;
  logic                    count_en, mem_we, init_ge;
  logic [WW-1:0]           wr_data;
  logic [COUNT_BITS:0]     rem2;
  logic                    step_ge;
  logic [HISTORY_BITS-1:0] succ0, succ1;
  logic [SW-1:0]           quo_ext;

  assign idx_h   = HISTORY_BITS'(in_item.entry_index);
  assign rd_addr = (in_item.cmd == CMD_READ) ? idx_h : history_r;

  assign zeros = rd_r[WW-1:COUNT_BITS];
  assign total = rd_r[COUNT_BITS-1:0];
  assign ones  = (zeros <= total) ? (total - zeros) : '0;

  // Count only after warm-up and while the total is below its maximum
  assign count_en = (warmup_r == 4'd0) && (total != {COUNT_BITS{1'b1}});
  assign mem_we   = ctl.clr || (ctl.upd && count_en);
  assign wr_addr  = ctl.clr ? clr_addr_r : addr_r;
  assign wr_data  = ctl.clr ? '0 :
                    {(bit_r ? zeros : zeros + COUNT_BITS'(1)), total + COUNT_BITS'(1)};

  // Table port: one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.accept) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Capture the item fields
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      addr_r <= rd_addr;
      bit_r  <= in_item.bit_value;
    end
  end

  // Shift the new bit in at the top
  always_comb begin
    history_nxt = (history_r >> 1) | (HISTORY_BITS'(bit_r) << (HISTORY_BITS - 1));
    warmup_nxt  = (warmup_r != 4'd0) ? warmup_r - 4'd1 : warmup_r;
  end

  // History, warm-up and clearing address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r  <= '0;
      warmup_r   <= 4'(HISTORY_BITS);
      clr_addr_r <= '0;
    end else begin
      if (ctl.upd) begin
        history_r <= history_nxt;
        warmup_r  <= warmup_nxt;
      end
      if (ctl.clr) begin
        clr_addr_r <= clr_addr_r + HISTORY_BITS'(1);
      end
    end
  end

  assign stat.clr_last   = (clr_addr_r == {HISTORY_BITS{1'b1}});
  assign stat.total_zero = (total == '0);
  assign stat.div_done   = (step_r == CW'(PROB_FRAC_BITS - 1));

  // Restoring division, one quotient bit a cycle
  assign init_ge = (ones >= total);
  assign rem2    = {rem_r, 1'b0};
  assign step_ge = (rem2 >= {1'b0, total});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (ctl.div_load) begin
      step_r <= '0;
    end else if (ctl.div_step) begin
      step_r <= step_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      if (total == '0) begin
        quo_r <= QW'(1) << (PROB_FRAC_BITS - 1);
        rem_r <= '0;
      end else begin
        quo_r <= QW'(init_ge);
        rem_r <= init_ge ? (ones - total) : ones;
      end
    end else if (ctl.div_step) begin
      quo_r <= {quo_r[QW-2:0], step_ge};
      rem_r <= step_ge ? COUNT_BITS'(rem2 - {1'b0, total}) : COUNT_BITS'(rem2);
    end
  end

  // Form successors and saturate the probability
  always_comb begin
    succ0   = addr_r >> 1;
    succ1   = succ0 | (HISTORY_BITS'(1) << (HISTORY_BITS - 1));
    quo_ext = SW'(quo_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_r.next_on_zero    <= SUCC_W'(succ0);
      out_r.next_on_one     <= SUCC_W'(succ1);
      out_r.one_probability <= (quo_ext > SW'({PROB_W{1'b1}})) ? {PROB_W{1'b1}}
                                                               : quo_ext[PROB_W-1:0];
    end
  end

  assign out_item = out_r;

endmodule

/* rtl/core/bhpt_ctrl.sv */
// Controller: sequences clearing, counter updates, reads and division.
`timescale 1ns / 1ps

module bhpt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            cmd,
  input  bhpt_pkg::stat_t stat,
  output bhpt_pkg::ctl_t  ctl,
  output logic            busy,
  output logic            out_valid
);
  import bhpt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE,
    S_LOOKUP,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;

  // Decode commands and pick the next state
  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = (cmd == CMD_READ) ? S_LOOKUP : S_UPDATE;
        end
      end
      S_UPDATE: begin
        ctl.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LOOKUP: begin
        ctl.div_load = 1'b1;
        state_nxt    = stat.total_zero ? S_FINISH : S_DIVIDE;
      end
      S_DIVIDE: begin
        ctl.div_step = 1'b1;
        if (stat.div_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        ctl.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= (state_r == S_FINISH);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

/* verif/tb_bit_history_probability_table_top.sv */
// Self-checking testbench for the bit history probability table: directed and random items.
`timescale 1ns / 1ps

module tb_bit_history_probability_table_top;
  import bhpt_pkg::*;

  localparam int          HIST_W      = 8;
  localparam int          FRAC_W      = 15;
  localparam int          TABLE_DEPTH = 1 << HIST_W;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [15:0] PROB_HALF   = 16'(1 << (FRAC_W - 1));
  localparam int          RANDOM_ITEMS = 1400;
  localparam int          QUIET_TAIL   = 150;
  localparam int          MAX_REPORTS  = 10;
  localparam int          CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  // Shadow state of the counter table
  logic [HIST_W-1:0] history;
  logic [3:0]        warmup_left;
  logic [31:0]       zero_counts [TABLE_DEPTH];
  logic [31:0]       total_counts [TABLE_DEPTH];

  in_t  pending_items [$];
  out_t expected_reads [$];

  int   total_items;
  int   accepted_cnt;
  int   mismatch_cnt;
  int   gap_left;
  int   cycle_cnt;
  logic taken;

  bit_history_probability_table_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic in_t make_item(logic cmd, logic bit_val, logic [7:0] idx);
    in_t it;
    it.cmd         = cmd;
    it.bit_value   = bit_val;
    it.entry_index = idx;
    return it;
  endfunction

  // Probability of a one in fixed point, half when the entry is empty
  function automatic logic [15:0] one_fraction(logic [31:0] zeros, logic [31:0] total);
    logic [63:0] ones;
    logic [63:0] quot;
    if (total == 32'd0) return PROB_HALF;
    ones = (zeros <= total) ? 64'(total - zeros) : 64'd0;
    quot = (ones << FRAC_W) / 64'(total);
    return (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
  endfunction

  // Count one observed bit, then shift it into the history
  function automatic void count_and_shift(logic b);
    if (warmup_left != 4'd0) begin
      warmup_left--;
    end else if (total_counts[history] != COUNT_MAX) begin
      if (!b) zero_counts[history]++;
      total_counts[history]++;
    end
    history = {b, history[HIST_W-1:1]};
  endfunction

  // Work out the expected result of an accepted item
  function automatic void predict_item(in_t it);
    out_t res;
    logic [HIST_W-1:0] idx;
    if (it.cmd == CMD_OBSERVE) begin
      count_and_shift(it.bit_value);
    end else begin
      idx                 = it.entry_index[HIST_W-1:0];
      res.next_on_zero    = 8'(idx >> 1);
      res.next_on_one     = 8'((idx >> 1) | (1 << (HIST_W - 1)));
      res.one_probability = one_fraction(zero_counts[idx], total_counts[idx]);
      expected_reads.push_back(res);
    end
  endfunction

  // Driver: present queued items, insert random idle bursts after acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_item  <= '0;
      gap_left = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        predict_item(in_item);
        accepted_cnt++;
      end
      if (taken || !start) begin
        if (taken && pending_items.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 19);
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          start   <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_reads.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: zero=%0d one=%0d prob=%0d",
                   out_item.next_on_zero, out_item.next_on_one, out_item.one_probability);
      end else begin
        out_t want;
        want = expected_reads.pop_front();
        if (out_item.next_on_zero !== want.next_on_zero ||
            out_item.next_on_one !== want.next_on_one ||
            out_item.one_probability !== want.one_probability) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("result mismatch: exp zero=%0d one=%0d prob=%0d, got zero=%0d one=%0d prob=%0d",
                     want.next_on_zero, want.next_on_one, want.one_probability,
                     out_item.next_on_zero, out_item.next_on_one, out_item.one_probability);
        end
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[bit_history_probability_table_top] ERROR");
      $finish;
    end
  end

  initial begin
    int seg_len;
    int bias;
    logic is_read;
    history      = '0;
    warmup_left  = 4'(HIST_W);
    accepted_cnt = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    gap_left     = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      zero_counts[i]  = '0;
      total_counts[i] = '0;
    end

    // Directed: empty entries, warm-up, all-ones and all-zeros entries
    pending_items.push_back(make_item(CMD_READ, 1'b1, 8'h00));
    pending_items.push_back(make_item(CMD_READ, 1'b0, 8'hFF));
    for (int i = 0; i < HIST_W; i++)
      pending_items.push_back(make_item(CMD_OBSERVE, 1'b1, 8'(i * 37)));
    pending_items.push_back(make_item(CMD_OBSERVE, 1'b1, 8'hFF));
    pending_items.push_back(make_item(CMD_OBSERVE, 1'b1, 8'h00));
    pending_items.push_back(make_item(CMD_READ, 1'b1, 8'hFF));
    for (int i = 0; i < HIST_W; i++)
      pending_items.push_back(make_item(CMD_OBSERVE, 1'b0, 8'(255 - i * 29)));
    pending_items.push_back(make_item(CMD_OBSERVE, 1'b0, 8'hAA));
    pending_items.push_back(make_item(CMD_READ, 1'b0, 8'h00));
    pending_items.push_back(make_item(CMD_READ, 1'b1, 8'h01));
    pending_items.push_back(make_item(CMD_READ, 1'b0, 8'hFF));

    // Random: segments of biased bit streams with reads mixed in
    while (pending_items.size() < RANDOM_ITEMS + 25) begin
      seg_len = $urandom_range(20, 80);
      bias    = $urandom_range(0, 16);
      for (int i = 0; i < seg_len; i++) begin
        is_read = ($urandom_range(0, 3) == 0);
        if (is_read)
          pending_items.push_back(make_item(CMD_READ, 1'($urandom), 8'($urandom)));
        else
          pending_items.push_back(make_item(CMD_OBSERVE,
                                            ($urandom_range(0, 15) < bias), 8'($urandom)));
      end
    end
    total_items = pending_items.size();

    // Hold reset, then release on a clock edge
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_items) @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (FRAC_W + 6) @(posedge clk);

    if (mismatch_cnt == 0 && expected_reads.size() == 0) begin
      $display("[bit_history_probability_table_top] OK");
    end else begin
      $display("[bit_history_probability_table_top] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bhpt_pkg.sv
rtl/core/bhpt_dp.sv
rtl/core/bhpt_ctrl.sv
rtl/core/bit_history_probability_table_top.sv
verif/tb_bit_history_probability_table_top.sv
